// ===== sv/rto_pkg.sv =====
// shared types for the rectangle ordering block
package rto_pkg;

  localparam int OUT_INDEX_W = 4;

  typedef struct packed {
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_bottom;
    logic signed [15:0] rect_right;
    logic [15:0]        monitor_tag;
    logic               last_item;
  } rect_in_t;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0] out_index;
    logic signed [15:0]     out_top;
    logic signed [15:0]     out_left;
    logic signed [15:0]     out_bottom;
    logic signed [15:0]     out_right;
    logic [15:0]            out_tag;
    logic                   out_last;
  } rect_out_t;

  // full stored entry: edges and tag
  typedef struct packed {
    logic signed [15:0] top;
    logic signed [15:0] left;
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic [15:0]        tag;
  } entry_t;

  // copy of the lower edges, read at a second address
  typedef struct packed {
    logic signed [15:0] bottom;
    logic signed [15:0] right;
  } far_edge_t;

endpackage

// ===== sv/rto_ram.sv =====
// generic single write, single read ram with registered read data
module rto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rect_topological_order.sv =====
// Rectangle ordering: loads up to MAX_RECTS rectangles, one per cycle while rect_ready
// is high, and on the transaction marked last_item orders the set so that every
// rectangle follows its blockers (i blocks j when top_i < bottom_j and left_i < right_j),
// taking the smallest (top, left) first, lowest load position on ties, and falling back
// to all unused rectangles when a cycle leaves none free. The blocker counts are built
// one pair per cycle from two copies of the store; each rank then takes a scan to pick,
// a choose step that waits until the result slot is free, and a count update sweep.
// The single shared compare unit and the one read port per store set this pace.
// The block takes no rectangle while ordering; the final result may still be waiting
// when loading of the next set begins.
module rect_topological_order #(
  parameter int MAX_RECTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rect_valid,
  output logic               rect_ready,
  input  rto_pkg::rect_in_t  rect,
  output logic               result_valid,
  input  logic               result_ready,
  output rto_pkg::rect_out_t result
);

  localparam int IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W   = $clog2(MAX_RECTS + 1);
  localparam int ENTRY_W = $bits(rto_pkg::entry_t);
  localparam int FAR_W   = $bits(rto_pkg::far_edge_t);

  typedef enum logic [2:0] {
    S_LOAD,
    S_BUILD,
    S_PICK,
    S_CHOOSE,
    S_DEC
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     loaded;
  logic [MAX_RECTS-1:0] used;
  logic [MAX_RECTS-1:0] unblocked;
  logic [IDX_W-1:0]     rnd;
  logic [IDX_W-1:0]     iss_i;
  logic [IDX_W-1:0]     iss_j;
  logic                 iss_on;
  logic                 stg_vld;
  logic [IDX_W-1:0]     stg_i;
  logic [IDX_W-1:0]     stg_j;
  logic [CNT_W-1:0]     acc;
  logic                 free_found;
  logic                 any_found;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     any_idx;
  rto_pkg::entry_t      free_ent;
  rto_pkg::entry_t      any_ent;
  logic [IDX_W-1:0]     sel_idx;

  logic                 load_we;
  rto_pkg::entry_t      load_ent;
  rto_pkg::far_edge_t   load_far;
  logic [ENTRY_W-1:0]   a_rdata;
  logic [FAR_W-1:0]     b_rdata;
  rto_pkg::entry_t      a_ent;
  rto_pkg::far_edge_t   b_far;
  logic [IDX_W-1:0]     b_raddr;
  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_waddr;
  logic [CNT_W-1:0]     cnt_wdata;
  logic [CNT_W-1:0]     cnt_rdata;
  logic [IDX_W-1:0]     last_idx;
  logic                 build_hit;
  logic [CNT_W-1:0]     acc_sum;
  logic                 dec_hit;
  logic                 cand_any;
  logic                 cand_free;
  logic                 take_any;
  logic                 take_free;
  logic                 out_free;
  rto_pkg::entry_t      ch_ent;
  logic [IDX_W-1:0]     ch_idx;

  function automatic logic ahead(rto_pkg::entry_t a, rto_pkg::entry_t b);
    ahead = (a.top < b.top) || ((a.top == b.top) && (a.left < b.left));
  endfunction

  assign rect_ready = (state == S_LOAD);
  assign load_we    = rect_valid && rect_ready && (loaded < CNT_W'(MAX_RECTS));
  assign last_idx   = IDX_W'(loaded - CNT_W'(1));

  always_comb begin
    load_ent.top    = rect.rect_top;
    load_ent.left   = rect.rect_left;
    load_ent.bottom = rect.rect_bottom;
    load_ent.right  = rect.rect_right;
    load_ent.tag    = rect.monitor_tag;
    load_far.bottom = rect.rect_bottom;
    load_far.right  = rect.rect_right;
  end

  assign a_ent   = rto_pkg::entry_t'(a_rdata);
  assign b_far   = rto_pkg::far_edge_t'(b_rdata);
  assign b_raddr = (state == S_BUILD) ? iss_j : iss_i;

  rto_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RECTS)) u_ram_ent (
    .clk   (clk),
    .we    (load_we),
    .waddr (loaded[IDX_W-1:0]),
    .wdata (ENTRY_W'(load_ent)),
    .raddr (iss_i),
    .rdata (a_rdata)
  );

  rto_ram #(.WIDTH(FAR_W), .DEPTH(MAX_RECTS)) u_ram_far (
    .clk   (clk),
    .we    (load_we),
    .waddr (loaded[IDX_W-1:0]),
    .wdata (FAR_W'(load_far)),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  rto_ram #(.WIDTH(CNT_W), .DEPTH(MAX_RECTS)) u_ram_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (iss_i),
    .rdata (cnt_rdata)
  );

  // shared compare unit: blocker test for the pair in the stage
  always_comb begin
    build_hit = (stg_i != stg_j) && (a_ent.top < b_far.bottom) && (a_ent.left < b_far.right);
    acc_sum   = ((stg_i == '0) ? '0 : acc) + CNT_W'(build_hit);
    dec_hit   = (stg_i != sel_idx) && (result.out_top < b_far.bottom)
                && (result.out_left < b_far.right);
    cand_any  = !used[stg_i];
    cand_free = cand_any && unblocked[stg_i];
    take_any  = cand_any && (!any_found || ahead(a_ent, any_ent));
    take_free = cand_free && (!free_found || ahead(a_ent, free_ent));
    out_free  = !result_valid || result_ready;
    ch_ent    = free_found ? free_ent : any_ent;
    ch_idx    = free_found ? free_idx : any_idx;
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = stg_i;
    cnt_wdata = cnt_rdata - CNT_W'(1);
    if (state == S_BUILD) begin
      cnt_we    = stg_vld && (stg_i == last_idx);
      cnt_waddr = stg_j;
      cnt_wdata = acc_sum;
    end else if (state == S_DEC) begin
      cnt_we = stg_vld && dec_hit && (cnt_rdata != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      loaded       <= '0;
      used         <= '0;
      iss_on       <= 1'b0;
      stg_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (load_we) begin
            loaded <= loaded + CNT_W'(1);
          end
          if (rect_valid && rect.last_item) begin
            state   <= S_BUILD;
            iss_i   <= '0;
            iss_j   <= '0;
            iss_on  <= 1'b1;
            stg_vld <= 1'b0;
          end
        end
        S_BUILD: begin
          stg_vld <= iss_on;
          stg_i   <= iss_i;
          stg_j   <= iss_j;
          if (iss_on) begin
            if (iss_i == last_idx) begin
              iss_i <= '0;
              if (iss_j == last_idx) begin
                iss_on <= 1'b0;
              end else begin
                iss_j <= iss_j + IDX_W'(1);
              end
            end else begin
              iss_i <= iss_i + IDX_W'(1);
            end
          end
          if (stg_vld) begin
            acc <= acc_sum;
            if (stg_i == last_idx) begin
              unblocked[stg_j] <= (acc_sum == '0);
              if (stg_j == last_idx) begin
                state      <= S_PICK;
                used       <= '0;
                rnd        <= '0;
                iss_i      <= '0;
                iss_on     <= 1'b1;
                stg_vld    <= 1'b0;
                free_found <= 1'b0;
                any_found  <= 1'b0;
              end
            end
          end
        end
        S_PICK: begin
          stg_vld <= iss_on;
          stg_i   <= iss_i;
          if (iss_on) begin
            if (iss_i == last_idx) begin
              iss_on <= 1'b0;
            end else begin
              iss_i <= iss_i + IDX_W'(1);
            end
          end
          if (stg_vld) begin
            if (take_any) begin
              any_found <= 1'b1;
              any_idx   <= stg_i;
              any_ent   <= a_ent;
            end
            if (take_free) begin
              free_found <= 1'b1;
              free_idx   <= stg_i;
              free_ent   <= a_ent;
            end
            if (stg_i == last_idx) begin
              state   <= S_CHOOSE;
              stg_vld <= 1'b0;
            end
          end
        end
        S_CHOOSE: begin
          if (out_free) begin
            result.out_index  <= rto_pkg::OUT_INDEX_W'(ch_idx);
            result.out_top    <= ch_ent.top;
            result.out_left   <= ch_ent.left;
            result.out_bottom <= ch_ent.bottom;
            result.out_right  <= ch_ent.right;
            result.out_tag    <= ch_ent.tag;
            result.out_last   <= (rnd == last_idx);
            result_valid      <= 1'b1;
            used[ch_idx]      <= 1'b1;
            sel_idx           <= ch_idx;
            if (rnd == last_idx) begin
              state  <= S_LOAD;
              loaded <= '0;
            end else begin
              state   <= S_DEC;
              rnd     <= rnd + IDX_W'(1);
              iss_i   <= '0;
              iss_on  <= 1'b1;
              stg_vld <= 1'b0;
            end
          end
        end
        S_DEC: begin
          stg_vld <= iss_on;
          stg_i   <= iss_i;
          if (iss_on) begin
            if (iss_i == last_idx) begin
              iss_on <= 1'b0;
            end else begin
              iss_i <= iss_i + IDX_W'(1);
            end
          end
          if (stg_vld) begin
            if (cnt_we) begin
              unblocked[stg_i] <= (cnt_wdata == '0);
            end
            if (stg_i == last_idx) begin
              state      <= S_PICK;
              iss_i      <= '0;
              iss_on     <= 1'b1;
              stg_vld    <= 1'b0;
              free_found <= 1'b0;
              any_found  <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== sv/rto_checker.sv =====
// port level checks for the rectangle ordering block, bound to the top level
module rto_checker (
  input logic               clk,
  input logic               rst,
  input logic               rect_valid,
  input logic               rect_ready,
  input rto_pkg::rect_in_t  rect,
  input logic               result_valid,
  input logic               result_ready,
  input rto_pkg::rect_out_t result
);

  // a waiting result transaction is not withdrawn
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result_valid dropped before the transaction completed");

  // the last rectangle of a set starts ordering, so loading stops
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    rect_valid && rect_ready && rect.last_item |=> !rect_ready)
    else $error("block took a rectangle right after the last one of a set");

  // a result other than the final one means the run is still going
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_last |-> !rect_ready)
    else $error("block ready for rectangles while a run is in progress");

  // reset leaves the block ready for loading
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> rect_ready && !result_valid)
    else $error("block not idle after reset");

endmodule

bind rect_topological_order rto_checker u_rto_checker (.*);
